// ===== hw/rtl/drb_pkg.sv =====
package drb_pkg;

    localparam int RING_BUFFERS      = 4;
    localparam int MAX_BUFFER_FRAMES = 1024;

    localparam int RATIO_W = 20;
    localparam int SIZE_W  = 11;
    localparam int PHASE_W = 21;
    localparam int FILL_W  = 10;
    localparam int FRAME_W = 32;
    localparam int RING_W  = $clog2(RING_BUFFERS);

    localparam int MAX_COPIES = 16;
    localparam int COPY_W     = $clog2(MAX_COPIES + 1);

    localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(65536);
    localparam logic [RATIO_W-1:0] MIN_RATIO = RATIO_W'(4096);

    localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(65536);
    localparam logic [SIZE_W-1:0]  SIZE_RESET  = SIZE_W'(800);

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = RATIO_W;

    localparam logic [CFG_INDEX_W-1:0] REG_STEP_RATIO        = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_FRAMES_PER_BUFFER = CFG_INDEX_W'(1);

    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;

    typedef enum logic [1:0]
    {
        ALU_ADD_STEP = 2'b01,
        ALU_SUB_ONE  = 2'b10
    } alu_op_t;

    typedef struct packed
    {
        logic [FILL_W-1:0] fill;
        logic [RING_W-1:0] ring;
        logic              last;
    } slot_t;

    function automatic logic [RATIO_W-1:0] eff_ratio(input logic [RATIO_W-1:0] r);
        return (r < MIN_RATIO) ? MIN_RATIO : r;
    endfunction

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        int v;
        v = int'(s);
        if (v == 0)
        begin
            v = 1;
        end
        if (v > MAX_BUFFER_FRAMES)
        begin
            v = MAX_BUFFER_FRAMES;
        end
        return SIZE_W'(v);
    endfunction

endpackage

// ===== hw/rtl/drop_repeat_resampler_buffer_fill.sv =====
// channel   dir  handshake            payload
// s_*       in   s_tvalid/s_tready    s_tdata frame_word, s_tuser chunk_start
// m_*       out  m_tvalid/m_tready    m_tdata frame/slot/buffer, m_tlast buffer_last
// cfg_*     in   cfg_we               cfg_index, cfg_data
//
// each input frame emits k copies, k = 0..16, set by the
// single phase adder that steps once per copy under the sequencer
// s_tready is high whenever the sequencer is idle, even while a beat waits on m_*
// a stalled m_tready holds the copy loop; no clearing pass after reset
module drop_repeat_resampler_buffer_fill
(
    input  logic                                   clk,
    input  logic                                   rst_n,

    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [drb_pkg::IN_TDATA_W-1:0]         s_tdata,  // [31:0] frame_word
    input  logic                                   s_tuser,  // [0] chunk_start

    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [31:0] out_frame, [41:32] slot_position, [43:42] buffer_number, [47:44] zero
    output logic [drb_pkg::OUT_TDATA_W-1:0]        m_tdata,
    output logic                                   m_tlast,  // buffer_last

    input  logic                                   cfg_we,
    input  logic [drb_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [drb_pkg::CFG_DATA_W-1:0]         cfg_data
);
    import drb_pkg::*;

    typedef enum logic [1:0]
    {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t             state_reg;
    state_t             state_next;

    logic [RATIO_W-1:0] ratio_reg;
    logic [SIZE_W-1:0]  size_reg;

    logic [PHASE_W-1:0] phase_reg;
    logic [PHASE_W-1:0] phase_next;
    logic [COPY_W-1:0]  copy_reg;
    logic [COPY_W-1:0]  copy_next;
    logic [FRAME_W-1:0] frame_reg;

    logic               out_valid_reg;
    logic [FRAME_W-1:0] out_frame_reg;
    logic [FILL_W-1:0]  out_slot_reg;
    logic [1:0]         out_buf_reg;
    logic               out_last_reg;

    alu_op_t            alu_op;
    logic [PHASE_W-1:0] alu_result;
    logic               below_one;

    slot_t              slot;
    logic               in_beat;
    logic               want_copy;
    logic               emit;
    logic               finish;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg <= RATIO_RESET;
            size_reg  <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STEP_RATIO:        ratio_reg <= cfg_data;
                REG_FRAMES_PER_BUFFER: size_reg  <= cfg_data[SIZE_W-1:0];
                default:               ;
            endcase
        end
    end

    drb_phase_alu u_alu
    (
        .op        (alu_op),
        .phase     (phase_reg),
        .ratio     (eff_ratio(ratio_reg)),
        .result    (alu_result),
        .below_one (below_one)
    );

    drb_slot_track u_slot
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (emit),
        .size    (eff_size(size_reg)),
        .slot    (slot)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_beat   = s_tvalid && s_tready;
    assign want_copy = (state_reg == ST_RUN) && below_one &&
                       (copy_reg < COPY_W'(MAX_COPIES));
    assign emit      = want_copy && (!out_valid_reg || m_tready);
    assign finish    = (state_reg == ST_RUN) && !want_copy;
    assign alu_op    = finish ? ALU_SUB_ONE : ALU_ADD_STEP;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        copy_next  = copy_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = ST_RUN;
                    copy_next  = '0;
                    if (s_tuser)
                    begin
                        phase_next = '0;
                    end
                end
            end
            ST_RUN:
            begin
                if (emit)
                begin
                    phase_next = alu_result;
                    copy_next  = copy_reg + COPY_W'(1);
                end
                else if (finish)
                begin
                    phase_next = below_one ? '0 : alu_result;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= '0;
            copy_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            copy_reg  <= copy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            frame_reg <= s_tdata[FRAME_W-1:0];
        end
    end

    // output register, loaded when empty or while the previous beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_frame_reg <= frame_reg;
            out_slot_reg  <= slot.fill;
            out_buf_reg   <= 2'(slot.ring);
            out_last_reg  <= slot.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W - FRAME_W - FILL_W - 2){1'b0}},
                       out_buf_reg, out_slot_reg, out_frame_reg};
    assign m_tlast  = out_last_reg;

endmodule

// ===== hw/rtl/drb_phase_alu.sv =====
module drb_phase_alu
(
    input  drb_pkg::alu_op_t                   op,
    input  logic [drb_pkg::PHASE_W-1:0]        phase,
    input  logic [drb_pkg::RATIO_W-1:0]        ratio,
    output logic [drb_pkg::PHASE_W-1:0]        result,
    output logic                               below_one
);
    import drb_pkg::*;

    logic [PHASE_W-1:0] operand_b;

    always_comb
    begin
        unique case (op)
            ALU_ADD_STEP: operand_b = PHASE_W'(ratio);
            ALU_SUB_ONE:  operand_b = PHASE_ONE;
            default:      operand_b = '0;
        endcase
    end

    // subtraction result is only kept when phase is at or above one, so a borrow never lands
    assign result    = (op == ALU_SUB_ONE) ? (phase - operand_b) : (phase + operand_b);
    assign below_one = (phase < PHASE_ONE);

endmodule

// ===== hw/rtl/drb_slot_track.sv =====
module drb_slot_track
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [drb_pkg::SIZE_W-1:0]    size,
    output drb_pkg::slot_t                slot
);
    import drb_pkg::*;

    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [RING_W-1:0] ring_reg;
    logic [RING_W-1:0] ring_next;
    logic              last;

    // a shrunk buffer size also lands here, so a stale fill closes at once
    assign last = ({1'b0, fill_reg} + SIZE_W'(1)) >= size;

    always_comb
    begin
        fill_next = fill_reg;
        ring_next = ring_reg;
        if (advance)
        begin
            if (last)
            begin
                fill_next = '0;
                ring_next = (ring_reg == RING_W'(RING_BUFFERS - 1)) ? '0
                                                                    : ring_reg + RING_W'(1);
            end
            else
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            ring_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            ring_reg <= ring_next;
        end
    end

    assign slot.fill = fill_reg;
    assign slot.ring = ring_reg;
    assign slot.last = last;

endmodule
